### rtl/psa_pkg.sv
// Shared types and constants for the patch stream applier.
// Parse phases, status codes, register indexes and header byte positions.
// No dependencies.
`timescale 1ns / 1ps

package psa_pkg;

  // Parse phase, one-hot
  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_ENTRY  = 4'b0010,
    PH_DATA   = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  // Stream status reported with every result
  typedef enum logic [2:0] {
    ST_BUSY          = 3'd0,
    ST_OK            = 3'd1,
    ST_SHORT_HEADER  = 3'd2,
    ST_BAD_MAGIC     = 3'd3,
    ST_BAD_VERSION   = 3'd4,
    ST_SIZE_MISMATCH = 3'd5,
    ST_TRUNCATED     = 3'd6,
    ST_OUT_OF_RANGE  = 3'd7
  } status_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OLD_SIZE = 2'd2;

  // Byte counter width covers the 32-byte header
  localparam int unsigned POS_W = 6;

  // Header: last byte of each little-endian field that is used
  localparam logic [POS_W-1:0] HDR_MAGIC_END   = 6'd3;
  localparam logic [POS_W-1:0] HDR_VERSION_END = 6'd7;
  localparam logic [POS_W-1:0] HDR_OLD_END     = 6'd15;
  localparam logic [POS_W-1:0] HDR_NEW_END     = 6'd23;
  localparam logic [POS_W-1:0] HDR_COUNT_END   = 6'd31;
  // First header position after the new size field
  localparam logic [POS_W-1:0] HDR_NEW_SEEN    = 6'd24;

  // Entry header: 64-bit offset then 32-bit length
  localparam logic [POS_W-1:0] ENT_OFFSET_END  = 6'd7;
  localparam logic [POS_W-1:0] ENT_LENGTH_END  = 6'd11;

endpackage

### rtl/psa_in_if.sv
// Patch byte request channel: valid/ready handshake with byte and end marker.
// Depends on nothing.
`timescale 1ns / 1ps

interface psa_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] patch_byte;
  logic       last_byte;

  modport source (output valid, output patch_byte, output last_byte, input ready);
  modport sink   (input valid, input patch_byte, input last_byte, output ready);
endinterface

### rtl/psa_out_if.sv
// Result channel: one result request per patch byte, valid/ready handshake.
// Depends on nothing.
`timescale 1ns / 1ps

interface psa_out_if;
  logic        valid;
  logic        ready;
  logic        write_valid;
  logic [63:0] write_offset;
  logic [7:0]  write_byte;
  logic        new_size_valid;
  logic [63:0] new_image_size;
  logic [2:0]  status;

  modport source (output valid, output write_valid, output write_offset,
                  output write_byte, output new_size_valid, output new_image_size,
                  output status, input ready);
  modport sink   (input valid, input write_valid, input write_offset,
                  input write_byte, input new_size_valid, input new_image_size,
                  input status, output ready);
endinterface

### rtl/psa_cfg_if.sv
// Configuration write channel: register index and 64-bit write data.
// Depends on nothing.
`timescale 1ns / 1ps

interface psa_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/patch_stream_applier.sv
// Top level of the patch stream applier: header check, entry parse, writes.
// Depends on psa_pkg and the psa_in_if, psa_out_if and psa_cfg_if interfaces.
`timescale 1ns / 1ps

// Usage
//   in_chan  : one patch byte per request, last_byte marks the end of a stream.
//   out_chan : exactly one result per patch byte: an optional write into the
//              new image, the new size once known, and the stream status.
//   cfg_chan : writes magic_word (0), format_version (1), old_image_size (2);
//              other indexes are ignored. Always ready; write only when idle.
// Timing
//   A byte is taken into an input register, parsed from there and its result
//   lands in the output register, from which it is offered. One byte per cycle
//   is sustained while out_chan is not stalled; the parse state (field shift
//   register, counters, write pointer) updates once per byte.
// Reset and stalls
//   rst_n (synchronous) clears configuration and parse state; the next byte
//   starts a new stream. While out_chan is stalled the output register holds
//   and the input register still fills once, then in_chan.ready drops.
//   After a last byte the parse state clears; configuration is kept.
module patch_stream_applier (
  input  logic    clk,
  input  logic    rst_n,
  psa_in_if.sink  in_chan,
  psa_out_if.source out_chan,
  psa_cfg_if.sink cfg_chan
);
  import psa_pkg::*;

  // Configuration registers
  logic [31:0] magic_r;
  logic [31:0] version_r;
  logic [63:0] old_size_r;

  // Input register
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // Parse state
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [63:0] shift_r, shift_nxt;
  phase_t      phase_r, phase_nxt;
  status_t     status_r, status_nxt;
  logic [63:0] img_size_r, img_size_nxt;
  logic [31:0] entries_r, entries_nxt;
  logic [63:0] ent_off_r, ent_off_nxt;
  logic [31:0] data_left_r, data_left_nxt;
  logic [63:0] wptr_r, wptr_nxt;

  // Output register
  logic        out_vld_r;
  logic        wv_r, wv_nxt;
  logic [63:0] wo_r, wo_nxt;
  logic [7:0]  wb_r, wb_nxt;
  logic        nsv_r, nsv_nxt;
  logic [63:0] nsz_r, nsz_nxt;
  status_t     st_r, st_nxt;

  logic        advance;
  logic        step;
  logic [63:0] shifted;
  logic [63:0] room;

  // Pipeline control
  assign advance       = !out_vld_r || out_chan.ready;
  assign step          = in_vld_r && advance;
  assign in_chan.ready = !in_vld_r || advance;
  assign cfg_chan.ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r    <= '0;
      version_r  <= '0;
      old_size_r <= '0;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        CFG_MAGIC:    magic_r    <= cfg_chan.data[31:0];
        CFG_VERSION:  version_r  <= cfg_chan.data[31:0];
        CFG_OLD_SIZE: old_size_r <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_byte_r <= in_chan.patch_byte;
      in_last_r <= in_chan.last_byte;
    end
  end

  // New byte enters the field shift register at the top
  assign shifted = {in_byte_r, shift_r[63:8]};
  // Room left in the new image after the entry offset
  assign room    = img_size_r - ent_off_r;

  // Parse step for one byte
  always_comb begin
    pos_nxt       = pos_r;
    shift_nxt     = shift_r;
    phase_nxt     = phase_r;
    status_nxt    = status_r;
    img_size_nxt  = img_size_r;
    entries_nxt   = entries_r;
    ent_off_nxt   = ent_off_r;
    data_left_nxt = data_left_r;
    wptr_nxt      = wptr_r;
    wv_nxt        = 1'b0;
    wo_nxt        = '0;
    wb_nxt        = '0;

    case (phase_r)
      PH_HEADER: begin
        shift_nxt = shifted;
        pos_nxt   = pos_r + 1'b1;
        case (pos_r)
          HDR_MAGIC_END: begin
            if (shifted[63:32] != magic_r) begin
              phase_nxt  = PH_DONE;
              status_nxt = ST_BAD_MAGIC;
            end
          end
          HDR_VERSION_END: begin
            if (shifted[63:32] != version_r) begin
              phase_nxt  = PH_DONE;
              status_nxt = ST_BAD_VERSION;
            end
          end
          HDR_OLD_END: begin
            if (shifted != old_size_r) begin
              phase_nxt  = PH_DONE;
              status_nxt = ST_SIZE_MISMATCH;
            end
          end
          HDR_NEW_END: img_size_nxt = shifted;
          HDR_COUNT_END: begin
            entries_nxt = shifted[63:32];
            if (shifted[63:32] == 32'd0) begin
              phase_nxt  = PH_DONE;
              status_nxt = ST_OK;
            end else begin
              phase_nxt = PH_ENTRY;
              pos_nxt   = '0;
            end
          end
          default: ;
        endcase
      end
      PH_ENTRY: begin
        shift_nxt = shifted;
        pos_nxt   = pos_r + 1'b1;
        case (pos_r)
          ENT_OFFSET_END: ent_off_nxt = shifted;
          ENT_LENGTH_END: begin
            data_left_nxt = shifted[63:32];
            if (ent_off_r > img_size_r || {32'd0, shifted[63:32]} > room) begin
              phase_nxt  = PH_DONE;
              status_nxt = ST_OUT_OF_RANGE;
            end else if (shifted[63:32] == 32'd0) begin
              // empty entry completes at once
              entries_nxt = entries_r - 1'b1;
              if (entries_r == 32'd1) begin
                phase_nxt  = PH_DONE;
                status_nxt = ST_OK;
              end else begin
                pos_nxt = '0;
              end
            end else begin
              phase_nxt = PH_DATA;
              wptr_nxt  = ent_off_r;
            end
          end
          default: ;
        endcase
      end
      PH_DATA: begin
        wv_nxt        = 1'b1;
        wo_nxt        = wptr_r;
        wb_nxt        = in_byte_r;
        wptr_nxt      = wptr_r + 64'd1;
        data_left_nxt = data_left_r - 1'b1;
        if (data_left_r == 32'd1) begin
          entries_nxt = entries_r - 1'b1;
          if (entries_r == 32'd1) begin
            phase_nxt  = PH_DONE;
            status_nxt = ST_OK;
          end else begin
            phase_nxt = PH_ENTRY;
            pos_nxt   = '0;
          end
        end
      end
      default: ;
    endcase

    // Result fields from the updated state
    case (phase_nxt)
      PH_HEADER: nsv_nxt = (pos_nxt >= HDR_NEW_SEEN);
      PH_ENTRY,
      PH_DATA:   nsv_nxt = 1'b1;
      default:   nsv_nxt = !(status_nxt == ST_BAD_MAGIC || status_nxt == ST_BAD_VERSION ||
                             status_nxt == ST_SIZE_MISMATCH);
    endcase
    nsz_nxt = img_size_nxt;
    st_nxt  = status_nxt;
    if (in_last_r && status_nxt == ST_BUSY) begin
      st_nxt = (phase_nxt == PH_HEADER) ? ST_SHORT_HEADER : ST_TRUNCATED;
    end

    // End of stream clears the parse state
    if (in_last_r) begin
      pos_nxt       = '0;
      shift_nxt     = '0;
      phase_nxt     = PH_HEADER;
      status_nxt    = ST_BUSY;
      img_size_nxt  = '0;
      entries_nxt   = '0;
      ent_off_nxt   = '0;
      data_left_nxt = '0;
      wptr_nxt      = '0;
    end
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      shift_r     <= '0;
      phase_r     <= PH_HEADER;
      status_r    <= ST_BUSY;
      img_size_r  <= '0;
      entries_r   <= '0;
      ent_off_r   <= '0;
      data_left_r <= '0;
      wptr_r      <= '0;
    end else if (step) begin
      pos_r       <= pos_nxt;
      shift_r     <= shift_nxt;
      phase_r     <= phase_nxt;
      status_r    <= status_nxt;
      img_size_r  <= img_size_nxt;
      entries_r   <= entries_nxt;
      ent_off_r   <= ent_off_nxt;
      data_left_r <= data_left_nxt;
      wptr_r      <= wptr_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      wv_r  <= wv_nxt;
      wo_r  <= wo_nxt;
      wb_r  <= wb_nxt;
      nsv_r <= nsv_nxt;
      nsz_r <= nsz_nxt;
      st_r  <= st_nxt;
    end
  end

  assign out_chan.valid          = out_vld_r;
  assign out_chan.write_valid    = wv_r;
  assign out_chan.write_offset   = wo_r;
  assign out_chan.write_byte     = wb_r;
  assign out_chan.new_size_valid = nsv_r;
  assign out_chan.new_image_size = nsz_r;
  assign out_chan.status         = st_r;

endmodule

### test/patch_write_checker.sv
// Checker for the patch stream applier: watches the three channels, predicts
// every result from the accepted patch bytes and compares field by field.
// Depends on psa_pkg.
`timescale 1ns / 1ps

module patch_write_checker
  import psa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_patch_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_write_valid,
  input  logic [63:0] out_write_offset,
  input  logic [7:0]  out_write_byte,
  input  logic        out_new_size_valid,
  input  logic [63:0] out_new_image_size,
  input  logic [2:0]  out_status,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          result_count,
  output int          write_count
);

  typedef struct packed {
    logic        wr_valid;
    logic [63:0] wr_offset;
    logic [7:0]  wr_byte;
    logic        size_valid;
    logic [63:0] size;
    status_t     status;
  } patch_result_t;

  // Register copies
  logic [31:0] magic_word;
  logic [31:0] format_version;
  logic [63:0] old_image_size;

  // Parser copy
  logic [POS_W-1:0] byte_pos;
  logic [63:0]      shift_reg;
  phase_t           phase;
  status_t          final_status;
  logic [63:0]      image_size;
  logic [31:0]      entries_left;
  logic [63:0]      entry_offset;
  logic [31:0]      data_left;
  logic [63:0]      write_ptr;

  patch_result_t expected_results[$];
  int errs = 0;
  int results = 0;
  int writes = 0;

  task automatic clear_stream();
    byte_pos     = '0;
    shift_reg    = '0;
    phase        = PH_HEADER;
    final_status = ST_BUSY;
    image_size   = '0;
    entries_left = '0;
    entry_offset = '0;
    data_left    = '0;
    write_ptr    = '0;
  endtask

  task automatic end_stream(input status_t s);
    phase        = PH_DONE;
    final_status = s;
  endtask

  task automatic close_entry();
    entries_left = entries_left - 1'b1;
    if (entries_left == '0) begin
      end_stream(ST_OK);
    end else begin
      phase    = PH_ENTRY;
      byte_pos = '0;
    end
  endtask

  // Advance the parser by one patch byte and work out its result
  task automatic predict_result(input logic [7:0] b, input logic lst,
                                output patch_result_t r);
    logic [POS_W-1:0] pos;
    pos = byte_pos;
    r   = '0;
    case (phase)
      PH_HEADER: begin
        shift_reg = {b, shift_reg[63:8]};
        byte_pos  = pos + 1'b1;
        case (pos)
          HDR_MAGIC_END:   if (shift_reg[63:32] != magic_word) end_stream(ST_BAD_MAGIC);
          HDR_VERSION_END: if (shift_reg[63:32] != format_version) end_stream(ST_BAD_VERSION);
          HDR_OLD_END:     if (shift_reg != old_image_size) end_stream(ST_SIZE_MISMATCH);
          HDR_NEW_END:     image_size = shift_reg;
          HDR_COUNT_END: begin
            entries_left = shift_reg[63:32];
            if (entries_left == '0) begin
              end_stream(ST_OK);
            end else begin
              phase    = PH_ENTRY;
              byte_pos = '0;
            end
          end
          default: ;
        endcase
      end
      PH_ENTRY: begin
        shift_reg = {b, shift_reg[63:8]};
        byte_pos  = pos + 1'b1;
        if (pos == ENT_OFFSET_END) begin
          entry_offset = shift_reg;
        end else if (pos == ENT_LENGTH_END) begin
          data_left = shift_reg[63:32];
          // entry must end within the new image, no wrap-around
          if (entry_offset > image_size || {32'd0, data_left} > image_size - entry_offset) begin
            end_stream(ST_OUT_OF_RANGE);
          end else if (data_left == '0) begin
            close_entry();
          end else begin
            phase     = PH_DATA;
            write_ptr = entry_offset;
          end
        end
      end
      PH_DATA: begin
        r.wr_valid  = 1'b1;
        r.wr_offset = write_ptr;
        r.wr_byte   = b;
        write_ptr   = write_ptr + 1'b1;
        data_left   = data_left - 1'b1;
        if (data_left == '0) close_entry();
      end
      default: ;
    endcase

    if (phase == PH_HEADER)
      r.size_valid = (byte_pos >= HDR_NEW_SEEN);
    else if (phase == PH_DONE)
      r.size_valid = !(final_status == ST_BAD_MAGIC || final_status == ST_BAD_VERSION ||
                       final_status == ST_SIZE_MISMATCH);
    else
      r.size_valid = 1'b1;
    r.size   = image_size;
    r.status = final_status;
    // end of stream while still busy
    if (lst && final_status == ST_BUSY)
      r.status = (phase == PH_HEADER) ? ST_SHORT_HEADER : ST_TRUNCATED;
    if (lst) clear_stream();
  endtask

  always @(posedge clk) begin
    patch_result_t want;
    patch_result_t got;
    if (!rst_n) begin
      magic_word     = '0;
      format_version = '0;
      old_image_size = '0;
      clear_stream();
      expected_results.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MAGIC:    magic_word     = cfg_data[31:0];
          CFG_VERSION:  format_version = cfg_data[31:0];
          CFG_OLD_SIZE: old_image_size = cfg_data;
          default: ;
        endcase
      end
      // byte requests
      if (in_valid && in_ready) begin
        predict_result(in_patch_byte, in_last_byte, want);
        expected_results = {expected_results, want};
      end
      // result requests
      if (out_valid && out_ready) begin
        got.wr_valid   = out_write_valid;
        got.wr_offset  = out_write_offset;
        got.wr_byte    = out_write_byte;
        got.size_valid = out_new_size_valid;
        got.size       = out_new_image_size;
        got.status     = status_t'(out_status);
        results++;
        if (out_write_valid === 1'b1) writes++;
        if (expected_results.size() == 0) begin
          $error("result request with nothing expected");
          errs++;
        end else begin
          want = expected_results.pop_front();
          if (got.wr_valid !== want.wr_valid) begin
            $error("write_valid: expected %0d, got %0d", want.wr_valid, got.wr_valid);
            errs++;
          end
          if (got.wr_offset !== want.wr_offset) begin
            $error("write_offset: expected 0x%h, got 0x%h", want.wr_offset, got.wr_offset);
            errs++;
          end
          if (got.wr_byte !== want.wr_byte) begin
            $error("write_byte: expected 0x%h, got 0x%h", want.wr_byte, got.wr_byte);
            errs++;
          end
          if (got.size_valid !== want.size_valid) begin
            $error("new_size_valid: expected %0d, got %0d", want.size_valid, got.size_valid);
            errs++;
          end
          if (got.size !== want.size) begin
            $error("new_image_size: expected 0x%h, got 0x%h", want.size, got.size);
            errs++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errs++;
          end
        end
      end
    end
    fail_count   <= errs;
    pending      <= expected_results.size();
    result_count <= results;
    write_count  <= writes;
  end

endmodule

### test/testbench.sv
// Top of the patch stream applier testbench: clock, reset, byte and register
// stimulus, result back-pressure, watchdog and verdict.
// Depends on psa_pkg, the three channel interfaces and patch_write_checker.
`timescale 1ns / 1ps

module testbench;
  import psa_pkg::*;

  localparam int RESET_CYCLES    = 4;
  localparam int STALL_LIMIT     = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 10;
  localparam int RANDOM_BYTES    = 600;
  localparam int CONFIG_ROUNDS   = 6;
  localparam int MAX_GAP         = 11;
  // index beyond the register file, must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst_n;

  always #1 clk = ~clk;

  psa_in_if  in_if ();
  psa_out_if out_if ();
  psa_cfg_if cfg_if ();

  patch_stream_applier i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  int fail_count;
  int pending;
  int result_count;
  int write_count;

  patch_write_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_if.valid),
    .in_ready           (in_if.ready),
    .in_patch_byte      (in_if.patch_byte),
    .in_last_byte       (in_if.last_byte),
    .out_valid          (out_if.valid),
    .out_ready          (out_if.ready),
    .out_write_valid    (out_if.write_valid),
    .out_write_offset   (out_if.write_offset),
    .out_write_byte     (out_if.write_byte),
    .out_new_size_valid (out_if.new_size_valid),
    .out_new_image_size (out_if.new_image_size),
    .out_status         (out_if.status),
    .cfg_valid          (cfg_if.valid),
    .cfg_ready          (cfg_if.ready),
    .cfg_index          (cfg_if.index),
    .cfg_data           (cfg_if.data),
    .fail_count         (fail_count),
    .pending            (pending),
    .result_count       (result_count),
    .write_count        (write_count)
  );

  logic [7:0]  patch_q[$];
  logic [31:0] cur_magic;
  logic [31:0] cur_version;
  logic [63:0] cur_old_size;
  int sent_bytes    = 0;
  int stream_count  = 0;
  int config_writes = 0;
  bit sender_quiet  = 1'b0;
  bit hold_off_req  = 1'b0;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Little-endian field into the patch being built
  task automatic add_le(input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) patch_q = {patch_q, v[8*i +: 8]};
  endtask

  task automatic add_header(input logic [63:0] new_sz, input logic [31:0] count);
    add_le(64'(cur_magic), 4);
    add_le(64'(cur_version), 4);
    add_le(cur_old_size, 8);
    add_le(new_sz, 8);
    add_le(64'($urandom), 4);
    add_le(64'(count), 4);
  endtask

  task automatic add_entry(input logic [63:0] off, input logic [31:0] len);
    add_le(off, 8);
    add_le(64'(len), 4);
    for (int i = 0; i < len; i++) patch_q = {patch_q, 8'($urandom_range(0, 255))};
  endtask

  // One byte request, after a random gap unless the sender is quiet
  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.patch_byte <= b;
    in_if.last_byte  <= lst;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sent_bytes++;
  endtask

  task automatic send_stream();
    for (int i = 0; i < patch_q.size(); i++) send_byte(patch_q[i], i == patch_q.size() - 1);
    patch_q.delete();
    stream_count++;
  endtask

  // Wait until every result is back, then let the pipeline settle
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all registers plus the unused index, only while idle
  task automatic write_regs(input logic [31:0] magic, input logic [31:0] version,
                            input logic [63:0] old_sz);
    logic [63:0] vals[4];
    vals[CFG_MAGIC]    = (rand64() & 64'hFFFF_FFFF_0000_0000) | {32'd0, magic};
    vals[CFG_VERSION]  = (rand64() & 64'hFFFF_FFFF_0000_0000) | {32'd0, version};
    vals[CFG_OLD_SIZE] = old_sz;
    vals[CFG_SPARE]    = rand64();
    for (int i = 0; i < 4; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= CFG_IDX_W'(i);
      cfg_if.data  <= vals[i];
      @(posedge clk);
      while (!cfg_if.ready) @(posedge clk);
      config_writes++;
    end
    cfg_if.valid <= 1'b0;
    cur_magic    = magic;
    cur_version  = version;
    cur_old_size = old_sz;
  endtask

  // Hand-built streams for the corner cases
  task automatic directed_streams();
    sender_quiet = 1'b0;
    // one byte then end: short header
    patch_q = {patch_q, 8'hFF};
    send_stream();
    // bad magic, then a trailing byte carrying the end marker
    add_le(64'(~cur_magic), 4);
    patch_q = {patch_q, 8'h00};
    send_stream();
    // bad version
    add_le(64'(cur_magic), 4);
    add_le(64'(cur_version ^ 32'h8000_0000), 4);
    patch_q = {patch_q, 8'hA5};
    send_stream();
    // old size mismatch
    add_le(64'(cur_magic), 4);
    add_le(64'(cur_version), 4);
    add_le(cur_old_size ^ 64'h1, 8);
    send_stream();
    // no entries, end marker on the final header byte
    add_header(64'h10, 32'd0);
    send_stream();
    // no entries, trailing bytes ignored
    add_header(rand64(), 32'd0);
    add_le(64'hFF00_FF, 3);
    send_stream();
    // largest new size: empty entry at the very end, entry ending exactly at it
    add_header(64'hFFFF_FFFF_FFFF_FFFF, 32'd2);
    add_entry(64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
    add_entry(64'hFFFF_FFFF_FFFF_FFFC, 32'd3);
    send_stream();
    // offset beyond the new size
    add_header(64'd8, 32'd1);
    add_entry(64'd9, 32'd0);
    send_stream();
    // length running past the new size
    add_header(64'd8, 32'd1);
    add_entry(64'd4, 32'd5);
    send_stream();
    // cut in the middle of entry data
    add_header(64'd100, 32'd2);
    add_entry(64'd0, 32'd4);
    add_entry(64'd10, 32'd5);
    void'(patch_q.pop_back());
    void'(patch_q.pop_back());
    send_stream();
    // cut inside an entry header
    add_header(64'd100, 32'd1);
    add_le(64'd3, 8);
    send_stream();
    // cut in the header after the new size is known
    add_header(64'd77, 32'd1);
    while (patch_q.size() > 26) void'(patch_q.pop_back());
    send_stream();
  endtask

  // One random stream: mostly well formed, some broken, some noise
  task automatic random_stream();
    int          kind;
    int          cut;
    int          idx;
    logic [63:0] new_sz;
    logic [63:0] off;
    logic [63:0] room;
    logic [31:0] count;
    logic [31:0] len;
    kind         = $urandom_range(0, 99);
    sender_quiet = ($urandom_range(0, 3) == 0);
    new_sz       = ($urandom_range(0, 3) == 0) ? rand64() : 64'($urandom_range(0, 300));
    count        = $urandom_range(0, 4);
    if (kind < 8) begin
      repeat ($urandom_range(1, 40)) patch_q = {patch_q, 8'($urandom_range(0, 255))};
    end else begin
      add_header(new_sz, count);
      if (kind < 12) begin
        idx = $urandom_range(0, 3);
        patch_q[idx] = patch_q[idx] ^ (8'd1 << $urandom_range(0, 7));
      end else if (kind < 16) begin
        idx = $urandom_range(4, 7);
        patch_q[idx] = patch_q[idx] ^ (8'd1 << $urandom_range(0, 7));
      end else if (kind < 20) begin
        idx = $urandom_range(8, 15);
        patch_q[idx] = patch_q[idx] ^ (8'd1 << $urandom_range(0, 7));
      end
      for (int e = 0; e < count; e++) begin
        len = $urandom_range(0, 6);
        if (kind >= 20 && kind < 26 && e == count - 1) begin
          // entry that does not fit
          if (new_sz != 64'hFFFF_FFFF_FFFF_FFFF && $urandom_range(0, 1) == 1) begin
            off = new_sz + 1'b1;
          end else begin
            off = new_sz;
            len = $urandom_range(1, 6);
          end
        end else begin
          if (len > new_sz) len = new_sz[31:0];
          room = new_sz - len;
          if ($urandom_range(0, 3) == 0)
            off = room;
          else
            off = (room == 64'hFFFF_FFFF_FFFF_FFFF) ? rand64() : rand64() % (room + 1'b1);
        end
        add_entry(off, len);
      end
      if (kind >= 26 && kind < 34 && patch_q.size() > 1) begin
        cut = $urandom_range(1, patch_q.size() - 1);
        while (patch_q.size() > cut) void'(patch_q.pop_back());
      end else if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) patch_q = {patch_q, 8'($urandom_range(0, 255))};
      end
    end
    send_stream();
  endtask

  // Result side back-pressure
  initial begin
    int stall;
    int served;
    bit quiet;
    bit held;
    served = 0;
    quiet  = 1'b0;
    held   = 1'b0;
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (served % 64 == 0) quiet = ($urandom_range(0, 2) == 0);
      if (hold_off_req && !held) begin
        held  = 1'b1;
        stall = HOLD_OFF_CYCLES;
      end else begin
        stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
      served++;
    end
  end

  // Watchdog on cycles without any request moving
  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        idle = 0;
      else
        idle++;
    end
    $display("Watchdog: no request moved for %0d cycles", STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    int target;
    rst_n            <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.patch_byte <= '0;
    in_if.last_byte  <= 1'b0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= '0;
    cfg_if.data      <= '0;
    cur_magic    = '0;
    cur_version  = '0;
    cur_old_size = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers still at their reset value of zero
    directed_streams();

    for (int r = 0; r < CONFIG_ROUNDS; r++) begin
      drain();
      case (r)
        0:       write_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        1:       write_regs(32'h0, 32'h0, 64'h0);
        2:       write_regs($urandom, $urandom, 64'($urandom_range(0, 4096)));
        default: write_regs($urandom, $urandom, rand64());
      endcase
      if (r == 0) directed_streams();
      // long result stall while bytes keep coming
      if (r == 2) hold_off_req = 1'b1;
      target = sent_bytes + RANDOM_BYTES / CONFIG_ROUNDS;
      while (sent_bytes < target) random_stream();
    end
    drain();

    $display("Covered %0d patch bytes in %0d streams across %0d register writes.",
             sent_bytes, stream_count, config_writes);
    $display("Checked %0d results, %0d of them image writes.", result_count, write_count);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
